// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the calendar conversion rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define E2C_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("e2c assertion failed");

`define E2C_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("e2c assertion failed");

`else

`define E2C_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define E2C_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- hw/rtl/e2c_pkg.sv -----
// types, constants and month table for the epoch to calendar converter
// no dependencies
package e2c_pkg;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;

    localparam logic [11:0] BASE_YEAR    = 12'd1970;
    localparam logic [1:0]  BASE_MOD4    = 2'd2;
    localparam logic [6:0]  BASE_MOD100  = 7'd70;
    localparam logic [8:0]  BASE_MOD400  = 9'd370;
    localparam logic [6:0]  LAST_MOD100  = 7'd99;
    localparam logic [8:0]  LAST_MOD400  = 9'd399;
    localparam logic [11:0] LAST_YEAR    = 12'd2106;

    localparam logic [8:0]  DAYS_YEAR      = 9'd365;
    localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;

    localparam logic [3:0]  MON_JAN = 4'd0;
    localparam logic [3:0]  MON_FEB = 4'd1;
    localparam logic [3:0]  MON_DEC = 4'd11;

    // reciprocals rounded up: 2^35 / 675 on seconds >> 7, 2^29 / 3600, 2^18 / 60
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam logic [17:0] HOUR_RECIP = 18'd149131;
    localparam logic [12:0] MIN_RECIP  = 13'd4370;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN
    } t_e2c_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAY,
        S_YEAR,
        S_MONTH,
        S_HOUR_INIT,
        S_HOUR,
        S_MIN_INIT,
        S_MIN,
        S_DONE
    } t_e2c_state;

    typedef struct packed {
        logic         load;
        logic         div_start;
        t_e2c_div_sel div_sel;
        logic         div_step;
        logic         year_step;
        logic         month_step;
        logic         out_load;
    } t_e2c_cmd;

    typedef struct packed {
        logic div_last;
        logic year_done;
        logic month_done;
        logic out_free;
    } t_e2c_stat;

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [16:0] divisor(input t_e2c_div_sel sel);
        logic [16:0] d;
        unique case (sel)
            DIV_DAY:  d = SECS_PER_DAY;
            DIV_HOUR: d = SECS_PER_HOUR;
            DIV_MIN:  d = SECS_PER_MIN;
            default:  d = SECS_PER_MIN;
        endcase
        return d;
    endfunction

endpackage

// ----- hw/rtl/e2c_ctrl.sv -----
// sequencer for the epoch to calendar converter
// depends on e2c_pkg
module e2c_ctrl
    import e2c_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_e2c_stat i_stat,
    output t_e2c_cmd  o_cmd
);

    t_e2c_state r_state;
    t_e2c_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.div_sel = DIV_DAY;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DAY;
                end
            end
            S_DAY: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_YEAR;
                end
            end
            S_YEAR: begin
                if (i_stat.year_done) begin
                    n_state = S_MONTH;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            S_MONTH: begin
                if (i_stat.month_done) begin
                    n_state = S_HOUR_INIT;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            S_HOUR_INIT: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_HOUR;
                n_state         = S_HOUR;
            end
            S_HOUR: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_MIN_INIT;
                end
            end
            S_MIN_INIT: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_MIN;
                n_state         = S_MIN;
            end
            S_MIN: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/e2c_dpath.sv -----
// datapath: reciprocal divider (quotient, then remainder), year walk and month walk
// depends on e2c_pkg and assert_macros.svh
`include "assert_macros.svh"

module e2c_dpath
    import e2c_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_e2c_cmd    i_cmd,
    input  logic [31:0] i_secs,
    output t_e2c_stat   o_stat,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    // divider: quotient in the first step, remainder in the second
    t_e2c_div_sel r_sel;
    logic [31:0]  r_num;
    logic [15:0]  r_quo;
    logic         r_phase;

    // results
    logic [15:0]  r_days;
    logic [16:0]  r_tod;
    logic [11:0]  r_msr;
    logic [4:0]   r_hour;
    logic [5:0]   r_minute;
    logic [5:0]   r_second;

    // calendar walk
    logic [11:0]  r_year;
    logic [1:0]   r_m4;
    logic [6:0]   r_m100;
    logic [8:0]   r_m400;
    logic [3:0]   r_mon;

    logic [16:0]  w_div;
    logic [50:0]  w_day_prod;
    logic [34:0]  w_hour_prod;
    logic [24:0]  w_min_prod;
    logic [15:0]  w_quo;
    logic [32:0]  w_back;
    logic [31:0]  w_rem;
    logic         w_leap;
    logic [8:0]   w_ylen;
    logic [4:0]   w_mlen;

    assign w_div       = divisor(r_sel);
    assign w_day_prod  = r_num[31:7] * DAY_RECIP;
    assign w_hour_prod = r_num[16:0] * HOUR_RECIP;
    assign w_min_prod  = r_num[11:0] * MIN_RECIP;

    always_comb begin
        unique case (r_sel)
            DIV_DAY:  w_quo = w_day_prod[50:35];
            DIV_HOUR: w_quo = {10'd0, w_hour_prod[34:29]};
            DIV_MIN:  w_quo = {9'd0, w_min_prod[24:18]};
            default:  w_quo = '0;
        endcase
    end

    assign w_back = r_quo * w_div;
    assign w_rem  = r_num - w_back[31:0];

    assign w_leap = (r_m4 == 2'd0) && ((r_m100 != 7'd0) || (r_m400 == 9'd0));
    assign w_ylen = w_leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
    assign w_mlen = month_len(r_mon, w_leap);

    assign o_stat.div_last   = r_phase;
    assign o_stat.year_done  = (r_days < {7'd0, w_ylen});
    assign o_stat.month_done = (r_mon == MON_DEC) || (r_days < {11'd0, w_mlen});
    assign o_stat.out_free   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sel   <= DIV_DAY;
            r_num   <= i_secs;
            r_phase <= 1'b0;
            r_year  <= BASE_YEAR;
            r_m4    <= BASE_MOD4;
            r_m100  <= BASE_MOD100;
            r_m400  <= BASE_MOD400;
            r_mon   <= MON_JAN;
        end else if (i_cmd.div_start) begin
            r_sel   <= i_cmd.div_sel;
            r_phase <= 1'b0;
            if (i_cmd.div_sel == DIV_HOUR) begin
                r_num <= {15'd0, r_tod};
            end else begin
                r_num <= {20'd0, r_msr};
            end
        end else if (i_cmd.div_step) begin
            r_phase <= ~r_phase;
            if (!r_phase) begin
                r_quo <= w_quo;
            end else begin
                unique case (r_sel)
                    DIV_DAY: begin
                        r_days <= r_quo;
                        r_tod  <= w_rem[16:0];
                    end
                    DIV_HOUR: begin
                        r_hour <= r_quo[4:0];
                        r_msr  <= w_rem[11:0];
                    end
                    DIV_MIN: begin
                        r_minute <= r_quo[5:0];
                        r_second <= w_rem[5:0];
                    end
                    default: begin
                        r_second <= w_rem[5:0];
                    end
                endcase
            end
        end else if (i_cmd.year_step) begin
            r_days <= r_days - {7'd0, w_ylen};
            r_year <= r_year + 12'd1;
            r_m4   <= r_m4 + 2'd1;
            r_m100 <= (r_m100 == LAST_MOD100) ? 7'd0 : r_m100 + 7'd1;
            r_m400 <= (r_m400 == LAST_MOD400) ? 9'd0 : r_m400 + 9'd1;
        end else if (i_cmd.month_step) begin
            r_days <= r_days - {11'd0, w_mlen};
            r_mon  <= r_mon + 4'd1;
        end
    end

    assign o_year   = r_year;
    assign o_month  = r_mon + 4'd1;
    assign o_day    = r_days[4:0] + 5'd1;
    assign o_hour   = r_hour;
    assign o_minute = r_minute;
    assign o_second = r_second;

    `E2C_ASSERT_IMP(a_year_in_range, i_clk, i_rst_n, i_cmd.year_step, r_year < LAST_YEAR)
    `E2C_ASSERT_IMP(a_month_in_range, i_clk, i_rst_n, i_cmd.month_step, r_mon < MON_DEC)
    `E2C_ASSERT_IMP(a_rem_below_div, i_clk, i_rst_n, i_cmd.div_step && r_phase, w_rem < {15'd0, w_div})
    `E2C_ASSERT_NXT(a_feb_len, i_clk, i_rst_n,
        i_cmd.month_step && (r_mon == MON_FEB), r_mon == 4'd2)

endmodule

// ----- hw/rtl/epoch_seconds_to_calendar.sv -----
// top level of the epoch seconds to calendar date and time converter
// depends on e2c_pkg, e2c_ctrl, e2c_dpath and assert_macros.svh
//
// Takes an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 and returns the
// Gregorian year, month, day, hour, minute and second, one result per item. The time an
// item takes grows with the years past 1970 (0..136) and the zero-based month, since the
// datapath walks the date one year and then one month at a time, the longest walk being
// late in 2105; a finished result also waits for the output register to drain. A
// reciprocal divider gives seconds per day, hour and minute. One item is worked on at a
// time; a finished result waits in the output register while the next item is taken in.
`include "assert_macros.svh"

module epoch_seconds_to_calendar
    import e2c_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // epoch_seconds[31:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata   // year, month, day_of_month, hour, minute, second, pad
);

    t_e2c_cmd    w_cmd;
    t_e2c_stat   w_stat;
    t_e2c_stat   w_dp_stat;
    logic [11:0] w_year;
    logic [3:0]  w_month;
    logic [4:0]  w_day;
    logic [4:0]  w_hour;
    logic [5:0]  w_minute;
    logic [5:0]  w_second;

    logic        r_m_tvalid;
    logic [39:0] r_m_tdata;

    always_comb begin
        w_stat          = w_dp_stat;
        w_stat.out_free = !r_m_tvalid || i_m_tready;
    end

    e2c_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    e2c_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_secs   (i_s_tdata),
        .o_stat   (w_dp_stat),
        .o_year   (w_year),
        .o_month  (w_month),
        .o_day    (w_day),
        .o_hour   (w_hour),
        .o_minute (w_minute),
        .o_second (w_second)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_m_tdata <= {2'b00, w_second, w_minute, w_hour, w_day, w_month, w_year};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    `E2C_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load,
        !r_m_tvalid || i_m_tready)
    `E2C_ASSERT_IMP(a_load_only_idle, i_clk, i_rst_n, w_cmd.load, !w_cmd.out_load)

endmodule
